/* hdl/pls_pkg.sv */
// Shared constants, operation codes and result type for the positional list store.
package pls_pkg;

  // List capacity, the widths that follow from it, and the fixed field widths.
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int OUT_W    = 7;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // One finished result as handed from the engine to the output stage.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] element;
    logic [OUT_W-1:0]         found_position;
    logic [OUT_W-1:0]         length;
  } res_t;

endpackage

/* hdl/positional_list_store.sv */
// Top level: request engine with element RAM, and the result output register.
// Clear and failed requests go straight to the result; get reads one entry, locate compares
// entries from the front, insert shifts entries up and writes the value, delete shifts down.
// Throughput is one request at a time; the shift walk through the element RAM, one entry
// per cycle on its one read port and one write port, sets insert and delete time.
// Reset clears the length to zero; RAM contents are never read before being written.
module positional_list_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_operation,
  input  logic [6:0]           in_position,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output logic signed [31:0]   out_element,
  output logic [6:0]           out_found_position,
  output logic [6:0]           out_length
);

  logic          res_valid, res_ready;
  pls_pkg::res_t res;
  pls_pkg::res_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  pls_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_r.ok;
  assign out_element        = out_r.element;
  assign out_found_position = out_r.found_position;
  assign out_length         = out_r.length;

`ifndef ASSERT_OFF
  // The engine never takes a new request while it still holds a result.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  // A new output only appears after the engine offered a result.
  a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("output valid without an engine result");

  // A failed request carries no element and no found position.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_element == '0 && out_found_position == '0))
    else $error("failed request carries data");

  // A found position is only reported by a successful request.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_position != '0) |-> out_ok)
    else $error("found position on a failed request");
`endif

endmodule

/* hdl/pls_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                   wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/pls_engine.sv */
// Request sequencer that reads, shifts and writes back list entries in the element RAM.
module pls_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_operation,
  input  logic [6:0]           in_position,
  input  logic signed [31:0]   in_value,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pls_pkg::res_t        res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_LOC,
    S_INS,
    S_PUT,
    S_DEL,
    S_RESULT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pls_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [pls_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [pls_pkg::ADDR_W-1:0]      tgt_r, tgt_nxt;
  logic [pls_pkg::DATA_W-1:0]      val_r, val_nxt;
  logic                            ok_r, ok_nxt;
  logic [pls_pkg::DATA_W-1:0]      elem_r, elem_nxt;
  logic [pls_pkg::CNT_W-1:0]       found_r, found_nxt;

  logic                            wr_en, rd_en;
  logic [pls_pkg::ADDR_W-1:0]      wr_addr, rd_addr;
  logic [pls_pkg::DATA_W-1:0]      wr_data, rd_data;

  logic [pls_pkg::CMP_W-1:0]       posx, cntx;
  logic                            pos_ok, ins_ok;
  logic                            at_last;

  pls_ram #(
    .WIDTH (pls_pkg::DATA_W),
    .DEPTH (pls_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Position checks against the current length.
  assign posx    = pls_pkg::CMP_W'(in_position);
  assign cntx    = pls_pkg::CMP_W'(count_r);
  assign pos_ok  = (posx != '0) && (posx <= cntx);
  assign ins_ok  = (posx != '0) && (posx <= cntx + 1'b1)
                   && (cntx < pls_pkg::CMP_W'(pls_pkg::CAPACITY));
  assign at_last = (pls_pkg::CNT_W'(addr_r) == count_r - 1'b1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);

  assign res.ok             = ok_r;
  assign res.element        = elem_r;
  assign res.found_position = pls_pkg::OUT_W'(found_r);
  assign res.length         = pls_pkg::OUT_W'(count_r);

  // Next-state logic and RAM access for each step of a request.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    tgt_nxt   = tgt_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    elem_nxt  = elem_r;
    found_nxt = found_r;
    wr_en     = 1'b0;
    wr_addr   = addr_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = addr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ok_nxt    = 1'b0;
          elem_nxt  = '0;
          found_nxt = '0;
          val_nxt   = in_value;
          state_nxt = S_RESULT;
          case (in_operation)
            pls_pkg::OP_GET: begin
              if (pos_ok) begin
                rd_en     = 1'b1;
                rd_addr   = pls_pkg::ADDR_W'(posx - 1'b1);
                state_nxt = S_GET;
              end
            end
            pls_pkg::OP_LOCATE: begin
              ok_nxt = 1'b1;
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                addr_nxt  = '0;
                state_nxt = S_LOC;
              end
            end
            pls_pkg::OP_INSERT: begin
              if (ins_ok) begin
                tgt_nxt = pls_pkg::ADDR_W'(posx - 1'b1);
                if (posx <= cntx) begin
                  // Entries from the position to the end move up by one.
                  rd_en     = 1'b1;
                  rd_addr   = pls_pkg::ADDR_W'(cntx - 1'b1);
                  addr_nxt  = pls_pkg::ADDR_W'(cntx - 1'b1);
                  state_nxt = S_INS;
                end else begin
                  state_nxt = S_PUT;
                end
              end
            end
            pls_pkg::OP_DELETE: begin
              if (pos_ok) begin
                if (posx < cntx) begin
                  // Entries after the position move down by one.
                  rd_en     = 1'b1;
                  rd_addr   = pls_pkg::ADDR_W'(posx);
                  addr_nxt  = pls_pkg::ADDR_W'(posx);
                  state_nxt = S_DEL;
                end else begin
                  count_nxt = count_r - 1'b1;
                  ok_nxt    = 1'b1;
                end
              end
            end
            pls_pkg::OP_CLEAR: begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_GET: begin
        elem_nxt  = rd_data;
        ok_nxt    = 1'b1;
        state_nxt = S_RESULT;
      end
      S_LOC: begin
        // Compare the entry read last cycle, stop at the first match or the end.
        if (rd_data == val_r) begin
          found_nxt = pls_pkg::CNT_W'(addr_r) + 1'b1;
          state_nxt = S_RESULT;
        end else if (at_last) begin
          state_nxt = S_RESULT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pls_pkg::ADDR_W'(addr_r + 1'b1);
          addr_nxt = pls_pkg::ADDR_W'(addr_r + 1'b1);
        end
      end
      S_INS: begin
        // Write the entry read last cycle one place up; walk downward.
        wr_en   = 1'b1;
        wr_addr = pls_pkg::ADDR_W'(addr_r + 1'b1);
        if (addr_r == tgt_r) begin
          state_nxt = S_PUT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pls_pkg::ADDR_W'(addr_r - 1'b1);
          addr_nxt = pls_pkg::ADDR_W'(addr_r - 1'b1);
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = tgt_r;
        wr_data   = val_r;
        count_nxt = count_r + 1'b1;
        ok_nxt    = 1'b1;
        state_nxt = S_RESULT;
      end
      S_DEL: begin
        // Write the entry read last cycle one place down; walk upward.
        wr_en   = 1'b1;
        wr_addr = pls_pkg::ADDR_W'(addr_r - 1'b1);
        if (at_last) begin
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pls_pkg::ADDR_W'(addr_r + 1'b1);
          addr_nxt = pls_pkg::ADDR_W'(addr_r + 1'b1);
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, length and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    addr_r  <= addr_nxt;
    tgt_r   <= tgt_nxt;
    val_r   <= val_nxt;
    ok_r    <= ok_nxt;
    elem_r  <= elem_nxt;
    found_r <= found_nxt;
  end

endmodule

/* verif/positional_list_store_tb.sv */
// Self-checking testbench for the positional list store: random list traffic against a predictor.
module positional_list_store_tb;

  localparam int OP_CODE_MAX   = (1 << pls_pkg::OP_W) - 1;
  localparam int GEN_VIEW      = 0;
  localparam int CHECK_VIEW    = 1;
  localparam int RANDOM_ITEMS  = 1330;
  localparam int SEGMENT       = 150;
  localparam int CALM_TAIL     = 150;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 150;

  // One request as queued for the driver; drain makes the driver wait for all replies first.
  typedef struct packed {
    logic [pls_pkg::OP_W-1:0]          op;
    logic [pls_pkg::POS_W-1:0]         pos;
    logic signed [pls_pkg::DATA_W-1:0] val;
    bit                                drain;
  } list_req_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_operation = '0;
  logic [6:0]               in_position = '0;
  logic signed [31:0]       in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic signed [31:0]       out_element;
  logic [6:0]               out_found_position;
  logic [6:0]               out_length;

  // Two copies of the list: one tracks generation, the other tracks accepted requests.
  logic signed [pls_pkg::DATA_W-1:0] list_cells [2][pls_pkg::CAPACITY];
  int                                list_count [2];

  list_req_t     pending_reqs[$];
  pls_pkg::res_t reply_queue[$];
  int            item_total = 0;
  int            accepted_count = 0;
  int            sent_count = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  int            fail_count = 0;
  int            replies_seen = 0;
  int            full_refusals = 0;
  int            peak_length = 0;
  int            locate_hits = 0;
  bit            tail_phase = 1'b0;

  positional_list_store dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_element        (out_element),
    .out_found_position (out_found_position),
    .out_length         (out_length)
  );

  always #1 clk = ~clk;

  // Apply one request to the selected list copy and return the reply it should produce.
  function automatic pls_pkg::res_t list_apply(input int view, input list_req_t rq);
    pls_pkg::res_t r;
    int            p;
    int            n;
    int            k;
    r = '0;
    p = int'(rq.pos);
    n = list_count[view];
    case (rq.op)
      pls_pkg::OP_GET: begin
        if (p >= 1 && p <= n) begin
          r.ok = 1'b1;
          r.element = list_cells[view][p-1];
        end
      end
      pls_pkg::OP_LOCATE: begin
        r.ok = 1'b1;
        for (k = 0; k < n; k++) begin
          if (r.found_position == '0 && list_cells[view][k] == rq.val)
            r.found_position = pls_pkg::OUT_W'(k + 1);
        end
      end
      pls_pkg::OP_INSERT: begin
        if (p >= 1 && p <= n + 1 && n < pls_pkg::CAPACITY) begin
          for (k = n; k >= p; k--)
            list_cells[view][k] = list_cells[view][k-1];
          list_cells[view][p-1] = rq.val;
          n++;
          r.ok = 1'b1;
        end
      end
      pls_pkg::OP_DELETE: begin
        if (p >= 1 && p <= n) begin
          for (k = p - 1; k + 1 < n; k++)
            list_cells[view][k] = list_cells[view][k+1];
          n--;
          r.ok = 1'b1;
        end
      end
      pls_pkg::OP_CLEAR: begin
        n = 0;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    list_count[view] = n;
    r.length = pls_pkg::OUT_W'(n);
    return r;
  endfunction

  // Queue a request and advance the generation copy so later picks see the real list.
  task automatic queue_req(input logic [pls_pkg::OP_W-1:0] op, input int pos,
                           input logic signed [pls_pkg::DATA_W-1:0] val, input bit drain);
    list_req_t     rq;
    pls_pkg::res_t r;
    rq.op = op;
    rq.pos = pls_pkg::POS_W'(pos);
    rq.val = val;
    rq.drain = drain;
    r = list_apply(GEN_VIEW, rq);
    if (rq.op == pls_pkg::OP_INSERT && !r.ok && list_count[GEN_VIEW] == pls_pkg::CAPACITY)
      full_refusals++;
    if (int'(r.length) > peak_length)
      peak_length = int'(r.length);
    if (rq.op == pls_pkg::OP_LOCATE && r.found_position != '0)
      locate_hits++;
    pending_reqs.push_back(rq);
  endtask

  // Mostly a legal position up to top, leaning on the ends; sometimes anything.
  function automatic int pick_pos(input int top);
    if (top < 1 || $urandom_range(0, 9) == 0)
      return int'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: return 1;
      1: return top;
      default: return int'($urandom_range(1, top));
    endcase
  endfunction

  // Request driver: presents the next queued request at the falling edge, with random gaps.
  always @(negedge clk) begin : drive_requests
    list_req_t nx;
    if (rst_n) begin
      if (sent_count == accepted_count) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && reply_queue.size() != 0)) begin
          nx = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_operation <= nx.op;
          in_position <= nx.pos;
          in_value <= nx.val;
          sent_count++;
          if (!tail_phase && $urandom_range(0, 4) == 0)
            gap_left = int'($urandom_range(1, 10));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply sink: stalls in random bursts until the calm tail of the run.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!tail_phase && $urandom_range(0, 5) == 0)
        stall_left = int'($urandom_range(1, 10));
    end
  end

  // Monitor: checks replies against the oldest prediction, then predicts new requests.
  always @(posedge clk) begin : watch_channels
    pls_pkg::res_t want;
    list_req_t     seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          $error("reply with no request outstanding");
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          replies_seen++;
          if (out_ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, out_element);
            fail_count++;
          end
          if (out_found_position !== want.found_position) begin
            $error("found_position: expected %0d, actual %0d", want.found_position,
                   out_found_position);
            fail_count++;
          end
          if (out_length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, out_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.op = in_operation;
        seen.pos = in_position;
        seen.val = in_value;
        seen.drain = 1'b0;
        reply_queue.push_back(list_apply(CHECK_VIEW, seen));
        accepted_count++;
      end
      tail_phase <= (item_total - sent_count) < CALM_TAIL;
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d replies outstanding", IDLE_LIMIT,
                 reply_queue.size());
        $display("positional_list_store_tb: FAIL");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases, then segments that grow, shrink or churn the list.
  initial begin : stimulus
    int                                n;
    int                                mode;
    int                                len;
    int                                roll;
    int                                ins_w;
    int                                del_w;
    bit                                drain;
    logic signed [pls_pkg::DATA_W-1:0] val;
    list_count[GEN_VIEW] = 0;
    list_count[CHECK_VIEW] = 0;
    mode = 0;

    // Empty list: reads, deletes and bad inserts all fail; locate succeeds with nothing found.
    queue_req(pls_pkg::OP_GET, 1, 0, 1'b0);
    queue_req(pls_pkg::OP_DELETE, 1, 0, 1'b0);
    queue_req(pls_pkg::OP_LOCATE, 0, 0, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 0, 5, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 2, 5, 1'b0);
    // Build [min, 0, max, -1] through front, end and middle inserts.
    queue_req(pls_pkg::OP_INSERT, 1, 32'sh7FFFFFFF, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 1, 32'sh80000000, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 3, -1, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 2, 0, 1'b0);
    queue_req(pls_pkg::OP_GET, 1, 0, 1'b0);
    queue_req(pls_pkg::OP_GET, 4, 0, 1'b0);
    queue_req(pls_pkg::OP_GET, 5, 0, 1'b0);
    queue_req(pls_pkg::OP_GET, 127, 0, 1'b0);
    queue_req(pls_pkg::OP_LOCATE, 0, -1, 1'b0);
    queue_req(pls_pkg::OP_LOCATE, 0, 32'sh80000000, 1'b0);
    queue_req(pls_pkg::OP_LOCATE, 0, 12345, 1'b0);
    queue_req(pls_pkg::OP_DELETE, 4, 0, 1'b0);
    queue_req(pls_pkg::OP_DELETE, 1, 0, 1'b0);
    queue_req(pls_pkg::OP_DELETE, 3, 0, 1'b0);
    // Undefined operation codes leave the list alone.
    queue_req(pls_pkg::OP_W'(pls_pkg::OP_CLEAR + 1), int'($urandom_range(0, 127)),
              $urandom, 1'b0);
    queue_req(pls_pkg::OP_W'(pls_pkg::OP_CLEAR + 2), int'($urandom_range(0, 127)),
              $urandom, 1'b0);
    queue_req(pls_pkg::OP_W'(OP_CODE_MAX), int'($urandom_range(0, 127)), $urandom, 1'b0);
    queue_req(pls_pkg::OP_CLEAR, 0, 0, 1'b0);
    queue_req(pls_pkg::OP_GET, 1, 0, 1'b0);
    queue_req(pls_pkg::OP_INSERT, 1, -2, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0)
        mode = ($urandom_range(0, 9) < 4) ? 0 : int'($urandom_range(1, 2));
      len = list_count[GEN_VIEW];
      ins_w = (mode == 0) ? 60 : (mode == 1) ? 15 : 30;
      del_w = (mode == 1) ? 45 : (mode == 0) ? 10 : 25;
      drain = (n == 0 || n == RANDOM_ITEMS / 2);
      roll = int'($urandom_range(0, 99));
      case ($urandom_range(0, 5))
        0: val = $signed(pls_pkg::DATA_W'($urandom_range(0, 7)));
        1: begin
          case ($urandom_range(0, 3))
            0: val = 32'sh7FFFFFFF;
            1: val = 32'sh80000000;
            2: val = -1;
            default: val = 0;
          endcase
        end
        default: val = $urandom;
      endcase
      if (roll < 3) begin
        queue_req(pls_pkg::OP_W'($urandom_range(pls_pkg::OP_CLEAR + 1, OP_CODE_MAX)),
                  int'($urandom_range(0, 127)), $urandom, drain);
      end else if (roll < 5 && mode != 0) begin
        queue_req(pls_pkg::OP_CLEAR, int'($urandom_range(0, 127)), val, drain);
      end else if (roll < 5 + ins_w) begin
        queue_req(pls_pkg::OP_INSERT, pick_pos(len + 1), val, drain);
      end else if (roll < 5 + ins_w + del_w) begin
        queue_req(pls_pkg::OP_DELETE, pick_pos(len), val, drain);
      end else if (roll < 5 + ins_w + del_w + (95 - ins_w - del_w) / 2) begin
        queue_req(pls_pkg::OP_GET, pick_pos(len), val, drain);
      end else begin
        // Locate mostly a value that is present, so matches land at every depth.
        if (len > 0 && $urandom_range(0, 2) != 0)
          val = list_cells[GEN_VIEW][$urandom_range(0, len - 1)];
        queue_req(pls_pkg::OP_LOCATE, int'($urandom_range(0, 127)), val, drain);
      end
    end
    item_total = pending_reqs.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count < item_total) @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d replies; peak length %0d of %0d", item_total,
             replies_seen, peak_length, pls_pkg::CAPACITY);
    $display("%0d inserts refused on a full list, %0d locates found their value",
             full_refusals, locate_hits);
    if (fail_count == 0) begin
      $display("positional_list_store_tb: PASS");
    end else begin
      $display("positional_list_store_tb: FAIL");
    end
    $finish;
  end

endmodule

/* positional_list_store.f */
hdl/pls_pkg.sv
hdl/pls_ram.sv
hdl/pls_engine.sv
hdl/positional_list_store.sv
verif/positional_list_store_tb.sv
